>>> src/tilt_compensated_orientation_unit_assert.svh
// assertion macros for the orientation unit, clocked on clk, off during reset
`ifndef TILT_COMPENSATED_ORIENTATION_UNIT_ASSERT_SVH
`define TILT_COMPENSATED_ORIENTATION_UNIT_ASSERT_SVH

// same-cycle implication
`define TCO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("orientation unit: property violated");

// next-cycle implication
`define TCO_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("orientation unit: property violated");

`endif

>>> src/tco_pkg.sv
`timescale 1ns / 1ps

package tco_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W = 32;
    localparam int ROLL_W = 16;
    localparam int PITCH_W = 15;
    localparam int HEAD_W = 16;

    // angle accumulator in 2^-20 degree
    localparam int ANG_FRAC = 20;
    localparam int ANGLE_W = 30;
    // cordic vector datapath
    localparam int DATA_W = 60;
    localparam int NORM_EXP = 54;
    localparam int TABLE_LEN = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // square root pipeline
    localparam int SQRT_IN_W = 48;
    localparam int SQRT_OUT_W = 24;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_LAT = SQRT_OUT_W / SQRT_PER_STAGE;

    localparam int FULL_LIMIT = 18000;
    localparam int PITCH_LIMIT = 9000;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(180 << ANG_FRAC);

    // atan(2^-i) in 2^-20 degree, rounded to nearest
    localparam logic signed [ANGLE_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

endpackage

>>> src/tilt_compensated_orientation_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// sensors   in         in_valid / in_stall  accel_x/y/z, mag_x/y/z, accel_time, mag_time
// angles    out        out_valid/out_stall  roll_angle, pitch_angle, heading_angle, sample_time
//
// one request per cycle while the output is not stalled; the pipeline depth is set by
// the 12-stage square root pipeline feeding the heading multiply and the cordic stage chain
// rst_n clears only the valid bits; payload registers are not reset
// out_stall with a result waiting freezes every stage at once and raises in_stall
`include "tilt_compensated_orientation_unit_assert.svh"

module tilt_compensated_orientation_unit #(
    parameter int CORDIC_STAGES = tco_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tco_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [tco_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [tco_pkg::SAMPLE_W-1:0] accel_z,
    input  logic signed [tco_pkg::SAMPLE_W-1:0] mag_x,
    input  logic signed [tco_pkg::SAMPLE_W-1:0] mag_y,
    input  logic signed [tco_pkg::SAMPLE_W-1:0] mag_z,
    input  logic [tco_pkg::TIME_W-1:0]          accel_time,
    input  logic [tco_pkg::TIME_W-1:0]          mag_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tco_pkg::ROLL_W-1:0]   roll_angle,
    output logic signed [tco_pkg::PITCH_W-1:0]  pitch_angle,
    output logic signed [tco_pkg::HEAD_W-1:0]   heading_angle,
    output logic [tco_pkg::TIME_W-1:0]          sample_time
);

    localparam int SW = tco_pkg::SAMPLE_W;
    localparam int TW = tco_pkg::TIME_W;
    localparam int DW = tco_pkg::DATA_W;
    localparam int AW = tco_pkg::ANGLE_W;
    localparam int PW = tco_pkg::PITCH_W;
    localparam int RW = tco_pkg::SQRT_OUT_W;
    localparam int MW = 49;
    localparam int DSW = MW + 1;
    localparam int SQ_LAT = tco_pkg::SQRT_LAT;
    localparam int C_LAT = 4 + CORDIC_STAGES;
    localparam int TOTAL = 5 + SQ_LAT + C_LAT;
    // side data waits from stage four until the roots come out
    localparam int SIDE_LEN = SQ_LAT - 1;
    // flags ride from the cordic input stage to the output
    localparam int TAIL_LEN = C_LAT + 3;
    localparam logic signed [PW-1:0] PITCH_UP = PW'(tco_pkg::PITCH_LIMIT);
    localparam logic signed [PW-1:0] PITCH_DOWN = PW'(-tco_pkg::PITCH_LIMIT);

    typedef struct packed {
        logic signed [SW-1:0] ax;
        logic signed [SW-1:0] ay;
        logic signed [SW-1:0] az;
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] my;
        logic signed [SW-1:0] mz;
        logic [TW-1:0]        stime;
        logic                 flat;
        logic                 axpos;
    } raw_t;

    typedef struct packed {
        raw_t               raw;
        logic signed [31:0] p_yy;
        logic signed [31:0] p_zz;
        logic signed [31:0] p_xx;
        logic signed [31:0] p_zy;
        logic signed [31:0] p_yz;
        logic signed [31:0] p_ym;
        logic signed [31:0] p_zm;
    } s1_t;

    typedef struct packed {
        raw_t               raw;
        logic [31:0]        ra2;
        logic [31:0]        g2;
        logic signed [32:0] hn;
        logic signed [32:0] tt;
    } s2_t;

    typedef struct packed {
        raw_t                raw;
        logic signed [32:0]  hn;
        logic signed [MW-1:0] mra;
        logic signed [MW-1:0] axt;
    } s3_t;

    typedef struct packed {
        logic signed [SW-1:0]  ax;
        logic signed [SW-1:0]  ay;
        logic signed [SW-1:0]  az;
        logic signed [SW-1:0]  my;
        logic signed [SW-1:0]  mz;
        logic [TW-1:0]         stime;
        logic                  flat;
        logic                  axpos;
        logic signed [32:0]    hn;
        logic signed [DSW-1:0] dsub;
    } side_t;

    typedef struct packed {
        logic signed [DW-1:0] roll_y;
        logic signed [DW-1:0] roll_x;
        logic signed [DW-1:0] pitch_y;
        logic signed [DW-1:0] pitch_x;
        logic signed [DW-1:0] head_y;
        logic signed [DW-1:0] head_x;
    } mid_t;

    typedef struct packed {
        logic [TW-1:0] stime;
        logic          flat;
        logic          axpos;
    } tail_t;

    logic             pipe_en;
    logic [TOTAL-1:0] vld_reg;
    logic [TOTAL-1:0] vld_next;

    s1_t   s1_reg;
    s1_t   s1_next;
    s2_t   s2_reg;
    s2_t   s2_next;
    s3_t   s3_reg;
    s3_t   s3_next;
    side_t side_reg [SIDE_LEN];
    side_t side_next;
    side_t sd;
    mid_t  mid_reg;
    mid_t  mid_next;
    tail_t tail_reg [TAIL_LEN];
    tail_t tail_next;
    tail_t tail_out;

    logic [RW-1:0] ra256;
    logic [RW-1:0] g256;
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;

    logic signed [AW-1:0] roll_z;
    logic signed [AW-1:0] pitch_z;
    logic signed [AW-1:0] head_z;
    logic signed [tco_pkg::ROLL_W-1:0] roll_cdeg;
    logic signed [PW-1:0]              pitch_cdeg;
    logic signed [tco_pkg::HEAD_W-1:0] head_cdeg;

    // the whole pipe moves unless a finished result is held back
    assign pipe_en = !vld_reg[TOTAL-1] || !out_stall;
    assign in_stall = !pipe_en;
    assign out_valid = vld_reg[TOTAL-1];
    assign vld_next = {vld_reg[TOTAL-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= vld_next;
    end

    // stage 1: sample products, latest timestamp and accel flags
    always_comb
    begin
        s1_next.raw.ax = accel_x;
        s1_next.raw.ay = accel_y;
        s1_next.raw.az = accel_z;
        s1_next.raw.mx = mag_x;
        s1_next.raw.my = mag_y;
        s1_next.raw.mz = mag_z;
        s1_next.raw.stime = (accel_time > mag_time) ? accel_time : mag_time;
        s1_next.raw.flat = (accel_y == '0) && (accel_z == '0);
        s1_next.raw.axpos = (accel_x > 0);
        s1_next.p_yy = 32'(accel_y) * 32'(accel_y);
        s1_next.p_zz = 32'(accel_z) * 32'(accel_z);
        s1_next.p_xx = 32'(accel_x) * 32'(accel_x);
        s1_next.p_zy = 32'(mag_z) * 32'(accel_y);
        s1_next.p_yz = 32'(mag_y) * 32'(accel_z);
        s1_next.p_ym = 32'(accel_y) * 32'(mag_y);
        s1_next.p_zm = 32'(accel_z) * 32'(mag_z);
    end

    // stage 2: squared norms, heading numerator core, y/z dot product
    always_comb
    begin
        s2_next.raw = s1_reg.raw;
        s2_next.ra2 = $unsigned(s1_reg.p_yy) + $unsigned(s1_reg.p_zz);
        s2_next.g2 = s2_next.ra2 + $unsigned(s1_reg.p_xx);
        s2_next.hn = 33'(s1_reg.p_zy) - 33'(s1_reg.p_yz);
        s2_next.tt = 33'(s1_reg.p_ym) + 33'(s1_reg.p_zm);
    end

    // stage 3: heading denominator products
    always_comb
    begin
        s3_next.raw = s2_reg.raw;
        s3_next.hn = s2_reg.hn;
        s3_next.mra = MW'(s2_reg.raw.mx) * MW'($signed({1'b0, s2_reg.ra2}));
        s3_next.axt = MW'(s2_reg.raw.ax) * MW'(s2_reg.tt);
    end

    // stage 4: denominator difference, start of the side delay
    always_comb
    begin
        side_next.ax = s3_reg.raw.ax;
        side_next.ay = s3_reg.raw.ay;
        side_next.az = s3_reg.raw.az;
        side_next.my = s3_reg.raw.my;
        side_next.mz = s3_reg.raw.mz;
        side_next.stime = s3_reg.raw.stime;
        side_next.flat = s3_reg.raw.flat;
        side_next.axpos = s3_reg.raw.axpos;
        side_next.hn = s3_reg.hn;
        side_next.dsub = DSW'(s3_reg.mra) - DSW'(s3_reg.axt);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            side_reg[0] <= side_next;
            for (int j = 1; j < SIDE_LEN; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // roots of the squared norms, scaled by 256
    tco_isqrt u_sqrt_ra (
        .clk      (clk),
        .en       (pipe_en),
        .radicand ({s2_reg.ra2, 16'b0}),
        .root     (ra256)
    );

    tco_isqrt u_sqrt_g (
        .clk      (clk),
        .en       (pipe_en),
        .radicand ({s2_reg.g2, 16'b0}),
        .root     (g256)
    );

    assign sd = side_reg[SIDE_LEN-1];

    // cordic operands; accel flat in y and z takes the heading from my and mz alone
    always_comb
    begin
        num = DW'(sd.hn) * DW'($signed({1'b0, g256}));
        den = DW'(sd.dsub) <<< 8;
        mid_next.roll_y = DW'(sd.ay);
        mid_next.roll_x = DW'(sd.az);
        mid_next.pitch_y = -(DW'(sd.ax) <<< 8);
        mid_next.pitch_x = DW'($signed({1'b0, ra256}));
        if (sd.flat)
        begin
            mid_next.head_y = -DW'(sd.my);
            mid_next.head_x = sd.axpos ? DW'(sd.mz) : -DW'(sd.mz);
        end
        else
        begin
            mid_next.head_y = num;
            mid_next.head_x = den;
        end
        tail_next.stime = sd.stime;
        tail_next.flat = sd.flat;
        tail_next.axpos = sd.axpos;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            mid_reg <= mid_next;
            tail_reg[0] <= tail_next;
            for (int j = 1; j < TAIL_LEN; j++)
            begin
                tail_reg[j] <= tail_reg[j-1];
            end
        end
    end

    tco_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
        .clk   (clk),
        .en    (pipe_en),
        .y_in  (mid_reg.roll_y),
        .x_in  (mid_reg.roll_x),
        .angle (roll_z)
    );

    tco_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .clk   (clk),
        .en    (pipe_en),
        .y_in  (mid_reg.pitch_y),
        .x_in  (mid_reg.pitch_x),
        .angle (pitch_z)
    );

    tco_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_head (
        .clk   (clk),
        .en    (pipe_en),
        .y_in  (mid_reg.head_y),
        .x_in  (mid_reg.head_x),
        .angle (head_z)
    );

    // scale to hundredths of a degree, two stages each
    tco_to_cdeg #(.OUT_W(tco_pkg::ROLL_W), .LIMIT(tco_pkg::FULL_LIMIT)) u_cdeg_roll (
        .clk   (clk),
        .en    (pipe_en),
        .angle (roll_z),
        .cdeg  (roll_cdeg)
    );

    tco_to_cdeg #(.OUT_W(PW), .LIMIT(tco_pkg::PITCH_LIMIT)) u_cdeg_pitch (
        .clk   (clk),
        .en    (pipe_en),
        .angle (pitch_z),
        .cdeg  (pitch_cdeg)
    );

    tco_to_cdeg #(.OUT_W(tco_pkg::HEAD_W), .LIMIT(tco_pkg::FULL_LIMIT)) u_cdeg_head (
        .clk   (clk),
        .en    (pipe_en),
        .angle (head_z),
        .cdeg  (head_cdeg)
    );

    assign tail_out = tail_reg[TAIL_LEN-1];

    // flat accel: pitch pinned to a quarter turn by the sign of ax
    assign roll_angle = roll_cdeg;
    assign pitch_angle = tail_out.flat ? (tail_out.axpos ? PITCH_UP : PITCH_DOWN) : pitch_cdeg;
    assign heading_angle = head_cdeg;
    assign sample_time = tail_out.stime;

    // a held result freezes every stage
    `TCO_ASSERT_NXT(a_stall_freeze, out_valid && out_stall, vld_reg == $past(vld_reg))
    `TCO_ASSERT_IMP(a_roll_range, out_valid, roll_angle <= 18000 && roll_angle >= -18000)
    `TCO_ASSERT_IMP(a_pitch_range, out_valid, pitch_angle <= 9000 && pitch_angle >= -9000)
    `TCO_ASSERT_IMP(a_head_range, out_valid,
        heading_angle <= 18000 && heading_angle >= -18000)

endmodule

>>> src/tco_isqrt.sv
`timescale 1ns / 1ps

module tco_isqrt (
    input  logic                            clk,
    input  logic                            en,
    input  logic [tco_pkg::SQRT_IN_W-1:0]   radicand,
    output logic [tco_pkg::SQRT_OUT_W-1:0]  root
);

    localparam int IW = tco_pkg::SQRT_IN_W;
    localparam int OW = tco_pkg::SQRT_OUT_W;
    localparam int REM_W = OW + 2;
    localparam int ACC_W = REM_W + 2;
    localparam int LAT = tco_pkg::SQRT_LAT;

    typedef struct packed {
        logic [IW-1:0]    v;
        logic [REM_W-1:0] rem;
        logic [OW-1:0]    root;
    } sq_t;

    // one restoring digit: two radicand bits in, one root bit out
    function automatic sq_t sq_step(sq_t s);
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] trial;
        sq_t r;
        acc = {s.rem, s.v[IW-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        r.v = {s.v[IW-3:0], 2'b00};
        if (acc >= trial)
        begin
            r.rem = REM_W'(acc - trial);
            r.root = {s.root[OW-2:0], 1'b1};
        end
        else
        begin
            r.rem = acc[REM_W-1:0];
            r.root = {s.root[OW-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_t seed;
    sq_t st_reg [LAT];

    assign seed = '{v: radicand, rem: '0, root: '0};

    genvar k;
    generate
        for (k = 0; k < LAT; k++)
        begin : g_stage
            sq_t src;
            sq_t stage_next;
            if (k == 0)
            begin : g_first
                assign src = seed;
            end
            else
            begin : g_rest
                assign src = st_reg[k-1];
            end
            always_comb
            begin
                stage_next = src;
                for (int j = 0; j < tco_pkg::SQRT_PER_STAGE; j++)
                begin
                    stage_next = sq_step(stage_next);
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    st_reg[k] <= stage_next;
            end
        end
    endgenerate

    assign root = st_reg[LAT-1].root;

endmodule

>>> src/tco_cordic.sv
`timescale 1ns / 1ps

module tco_cordic #(
    parameter int STAGES = tco_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [tco_pkg::DATA_W-1:0]  y_in,
    input  logic signed [tco_pkg::DATA_W-1:0]  x_in,
    output logic signed [tco_pkg::ANGLE_W-1:0] angle
);

    localparam int DW = tco_pkg::DATA_W;
    localparam int AW = tco_pkg::ANGLE_W;
    localparam int NE = tco_pkg::NORM_EXP;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] z;
        logic [DW-1:0]        m;
    } norm_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] z;
    } rot_t;

    // shift left by sh if the magnitude is below 2^thr_exp
    function automatic norm_t norm_step(norm_t s, int thr_exp, int sh);
        logic [DW-1:0] thr;
        norm_t r;
        thr = {{(DW-1){1'b0}}, 1'b1} << thr_exp;
        r = s;
        if (s.m < thr)
        begin
            r.x = s.x <<< sh;
            r.y = s.y <<< sh;
            r.m = s.m << sh;
        end
        return r;
    endfunction

    norm_t fold_reg;
    norm_t fold_next;
    norm_t norm_reg [3];
    norm_t norm_next [3];
    rot_t  rot_reg [STAGES];
    logic signed [DW-1:0] y_abs;

    // fold into the right half plane
    always_comb
    begin
        fold_next.x = x_in;
        fold_next.y = y_in;
        fold_next.z = '0;
        if (x_in < 0)
        begin
            fold_next.x = -x_in;
            fold_next.y = -y_in;
            fold_next.z = (y_in >= 0) ? tco_pkg::HALF_TURN : -tco_pkg::HALF_TURN;
        end
        y_abs = (fold_next.y < 0) ? -fold_next.y : fold_next.y;
        fold_next.m = $unsigned((fold_next.x > y_abs) ? fold_next.x : y_abs);
    end

    // normalize a nonzero magnitude to at least 2^54, binary search over three stages
    always_comb
    begin
        norm_next[0] = norm_step(norm_step(fold_reg, NE - 32, 32), NE - 16, 16);
        norm_next[1] = norm_step(norm_step(norm_reg[0], NE - 8, 8), NE - 4, 4);
        norm_next[2] = norm_step(norm_step(norm_step(norm_reg[1], NE - 2, 2),
                                           NE - 1, 1), NE, 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
            norm_reg <= norm_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_rot
            rot_t src;
            rot_t stage_next;
            logic signed [DW-1:0] xs;
            logic signed [DW-1:0] ys;
            if (i == 0)
            begin : g_first
                assign src = '{x: norm_reg[2].x, y: norm_reg[2].y, z: norm_reg[2].z};
            end
            else
            begin : g_rest
                assign src = rot_reg[i-1];
            end
            always_comb
            begin
                xs = src.x >>> i;
                ys = src.y >>> i;
                stage_next = src;
                if (src.y > 0)
                begin
                    stage_next.x = src.x + ys;
                    stage_next.y = src.y - xs;
                    stage_next.z = src.z + tco_pkg::ATAN_TAB[i];
                end
                else if (src.y < 0)
                begin
                    stage_next.x = src.x - ys;
                    stage_next.y = src.y + xs;
                    stage_next.z = src.z - tco_pkg::ATAN_TAB[i];
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    rot_reg[i] <= stage_next;
            end
        end
    endgenerate

    assign angle = rot_reg[STAGES-1].z;

endmodule

>>> src/tco_to_cdeg.sv
`timescale 1ns / 1ps

module tco_to_cdeg #(
    parameter int OUT_W = tco_pkg::ROLL_W,
    parameter int LIMIT = tco_pkg::FULL_LIMIT
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [tco_pkg::ANGLE_W-1:0] angle,
    output logic signed [OUT_W-1:0]            cdeg
);

    localparam int AW = tco_pkg::ANGLE_W;
    localparam int FR = tco_pkg::ANG_FRAC;
    localparam int PROD_W = AW + 8;
    localparam int RND_W = PROD_W - FR;
    localparam int VAL_W = RND_W + 1;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FR - 1);
    localparam logic signed [VAL_W-1:0] LIM_V = VAL_W'(LIMIT);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [OUT_W-1:0]  cdeg_reg;
    logic signed [OUT_W-1:0]  cdeg_next;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        sum;
    logic signed [VAL_W-1:0]  val;

    assign prod_next = PROD_W'(angle) * PROD_W'(100);

    // round half away from zero, then clamp
    always_comb
    begin
        mag = (prod_reg < 0) ? $unsigned(-prod_reg) : $unsigned(prod_reg);
        sum = mag + HALF;
        val = $signed({1'b0, sum[PROD_W-1:FR]});
        if (prod_reg < 0)
            val = -val;
        if (val > LIM_V)
            val = LIM_V;
        if (val < -LIM_V)
            val = -LIM_V;
        cdeg_next = OUT_W'(val);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            cdeg_reg <= cdeg_next;
        end
    end

    assign cdeg = cdeg_reg;

endmodule

>>> bench/tilt_compensated_orientation_unit_tb.sv
`timescale 1ns / 1ps

module tilt_compensated_orientation_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic signed [tco_pkg::ROLL_W-1:0]  roll;
        logic signed [tco_pkg::PITCH_W-1:0] pitch;
        logic signed [tco_pkg::HEAD_W-1:0]  heading;
        logic [tco_pkg::TIME_W-1:0]         stamp;
    } angles_t;

    // predicted angles, computed in 64-bit integer math at the block's formats
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint m;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? (longint'(180) <<< tco_pkg::ANG_FRAC)
                         : -(longint'(180) <<< tco_pkg::ANG_FRAC);
            x = -x;
            y = -y;
        end
        m = (y < 0) ? -y : y;
        if (x > m)
            m = x;
        while (m < (longint'(1) <<< tco_pkg::NORM_EXP))
        begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < tco_pkg::CORDIC_STAGES_DEF && i < tco_pkg::TABLE_LEN; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(tco_pkg::ATAN_TAB[i]);
            end
            else if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(tco_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint centidegrees(longint z, longint lim);
        longint n;
        longint half;
        longint r;
        n = z * 100;
        half = longint'(1) <<< (tco_pkg::ANG_FRAC - 1);
        r = (n >= 0) ? ((n + half) >>> tco_pkg::ANG_FRAC)
                     : -((-n + half) >>> tco_pkg::ANG_FRAC);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic angles_t predict_orientation(longint ax, longint ay, longint az,
                                                    longint mx, longint my, longint mz,
                                                    logic [tco_pkg::TIME_W-1:0] ta,
                                                    logic [tco_pkg::TIME_W-1:0] tm);
        angles_t a;
        longint p;
        longint h;
        longint ra2;
        longint ra256;
        longint g256;
        longint num;
        longint den;
        a.roll = tco_pkg::ROLL_W'(centidegrees(vector_angle(ay, az), tco_pkg::FULL_LIMIT));
        if (ay == 0 && az == 0)
        begin
            // accel along x only: pitch pinned to a quarter turn
            p = (ax > 0) ? tco_pkg::PITCH_LIMIT : -tco_pkg::PITCH_LIMIT;
            h = centidegrees(vector_angle(-my, (ax > 0) ? mz : -mz), tco_pkg::FULL_LIMIT);
        end
        else
        begin
            ra2 = ay * ay + az * az;
            ra256 = int_sqrt(longint'(ra2) << 16);
            g256 = int_sqrt(longint'(ra2 + ax * ax) << 16);
            num = (mz * ay - my * az) * g256;
            den = (mx * ra2 - ax * (ay * my + az * mz)) * 256;
            p = centidegrees(vector_angle(-ax * 256, ra256), tco_pkg::PITCH_LIMIT);
            h = centidegrees(vector_angle(num, den), tco_pkg::FULL_LIMIT);
        end
        a.pitch = tco_pkg::PITCH_W'(p);
        a.heading = tco_pkg::HEAD_W'(h);
        a.stamp = (ta > tm) ? ta : tm;
        return a;
    endfunction

    // scoreboard: queue of predicted angle sets in request order
    class angle_scoreboard;
        angles_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(angles_t a);
            pending.push_back(a);
        endfunction

        function void check_result(angles_t got);
            angles_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.roll !== want.roll)
            begin
                $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
                errors++;
            end
            if (got.pitch !== want.pitch)
            begin
                $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
                errors++;
            end
            if (got.heading !== want.heading)
            begin
                $display("%0t: heading expected %0d actual %0d", $time,
                         want.heading, got.heading);
                errors++;
            end
            if (got.stamp !== want.stamp)
            begin
                $display("%0t: time expected %0d actual %0d", $time, want.stamp, got.stamp);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [tco_pkg::SAMPLE_W-1:0] accel_x, accel_y, accel_z;
    logic signed [tco_pkg::SAMPLE_W-1:0] mag_x, mag_y, mag_z;
    logic [tco_pkg::TIME_W-1:0] accel_time, mag_time;
    logic out_valid;
    logic out_stall;
    logic signed [tco_pkg::ROLL_W-1:0] roll_angle;
    logic signed [tco_pkg::PITCH_W-1:0] pitch_angle;
    logic signed [tco_pkg::HEAD_W-1:0] heading_angle;
    logic [tco_pkg::TIME_W-1:0] sample_time;

    angle_scoreboard board;
    int idle_count;
    int sent;
    int received;
    bit calm;   // no idling on either side during the closing stretch

    tilt_compensated_orientation_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
        .accel_time(accel_time), .mag_time(mag_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .heading_angle(heading_angle), .sample_time(sample_time)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result side: sample at the edge, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_result('{roll_angle, pitch_angle, heading_angle, sample_time});
            received++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, idle_count);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stalls in random bursts, none in the closing stretch
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 18);
            if (!calm && $urandom_range(0, 2) == 0)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
            repeat (n) @(posedge clk);
        end
    end

    // present one request and hold it until accepted
    task automatic send_request(logic [tco_pkg::SAMPLE_W-1:0] ax,
                                logic [tco_pkg::SAMPLE_W-1:0] ay,
                                logic [tco_pkg::SAMPLE_W-1:0] az,
                                logic [tco_pkg::SAMPLE_W-1:0] mx,
                                logic [tco_pkg::SAMPLE_W-1:0] my,
                                logic [tco_pkg::SAMPLE_W-1:0] mz,
                                logic [tco_pkg::TIME_W-1:0] ta,
                                logic [tco_pkg::TIME_W-1:0] tm);
        in_valid <= 1'b1;
        accel_x <= ax;
        accel_y <= ay;
        accel_z <= az;
        mag_x <= mx;
        mag_y <= my;
        mag_z <= mz;
        accel_time <= ta;
        mag_time <= tm;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(predict_orientation($signed(ax), $signed(ay), $signed(az),
                                               $signed(mx), $signed(my), $signed(mz),
                                               ta, tm));
        sent++;
        // random gap burst between requests
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function automatic logic [tco_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return tco_pkg::SAMPLE_W'($urandom_range(0, 8)) - 16'd4;
            3: return tco_pkg::SAMPLE_W'($urandom_range(0, 2000)) - 16'd1000;
            default: return tco_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [tco_pkg::SAMPLE_W-1:0] s [6];
        int total;
        board = new();
        idle_count = 0;
        sent = 0;
        received = 0;
        calm = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        mag_x = '0;
        mag_y = '0;
        mag_z = '0;
        accel_time = '0;
        mag_time = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: level, extremes, flat-in-x both signs, zero vectors,
        // negative z with zero y (half turn), timestamp ordering
        send_request(0, 0, 16384, 16384, 0, 0, 100, 50);
        send_request(0, 0, 0, 0, 0, 0, 0, 0);
        send_request(1000, 0, 0, 100, 200, 300, 5, 9);
        send_request(-1000, 0, 0, 100, 200, -300, 32'hffff_ffff, 0);
        send_request(0, 0, 0, 5, -7, 9, 1, 1);
        send_request(0, 0, -16384, 0, 0, 0, 0, 32'hffff_ffff);
        send_request(0, 0, -16384, 500, 0, -200, 7, 3);
        send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                     32'h8000_0000, 32'h7fff_ffff);
        send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     32'h7fff_ffff, 32'h8000_0000);
        send_request(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 3, 4);
        send_request(16'h7fff, 0, 1, 0, 16'h8000, 0, 10, 10);
        send_request(1, 16'h8000, 0, 0, 0, 16'h7fff, 2, 1);
        send_request(0, 16384, 0, 0, 0, 0, 0, 0);
        send_request(0, -16384, 0, 0, 0, 1000, 0, 0);
        send_request(16384, 0, 16384, 100, -100, 100, 0, 0);
        send_request(-16384, 1, 16384, -1, -1, -1, 0, 0);

        // random: mixed sample styles; no idling over the last stretch
        total = 950;
        for (int k = 0; k < total; k++)
        begin
            if (k == total - 150)
                calm = 1;
            foreach (s[j])
                s[j] = rand_sample();
            if ($urandom_range(0, 15) == 0)
            begin
                s[1] = '0;
                s[2] = '0;
            end
            send_request(s[0], s[1], s[2], s[3], s[4], s[5], $urandom(), $urandom());
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d sensor requests, checked %0d angle results", sent, received);
        $display("directed extremes, flat-x and zero cases plus random stall bursts");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
